>>> rtl/sd_spi_command_engine_macros.svh
// Assertion helpers for the SD SPI command engine.
`ifndef SD_SPI_COMMAND_ENGINE_MACROS_SVH
`define SD_SPI_COMMAND_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

`define SDSPI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define SDSPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SDSPI_ASSERT_IMP(lbl, ante, cons, msg)

`define SDSPI_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/sdspi_pkg.sv
package sdspi_pkg;

  localparam int MAX_BLOCK_BYTES_DEF = 512;

  localparam int POLL_W     = 17;
  localparam int RESP_LIM_W = 8;
  localparam int DLEN_W     = 10;
  localparam int FRAME_W    = 48;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [7:0] CMD_MARK  = 8'h40;
  localparam logic [2:0] FRAME_BYTES = 3'd6;

  localparam logic OP_START = 1'b0;
  localparam logic OP_RX    = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_READY_TO   = 3'd1;
  localparam logic [2:0] ST_RESP_TO    = 3'd2;
  localparam logic [2:0] ST_NONZERO_R1 = 3'd3;
  localparam logic [2:0] ST_TOKEN_TO   = 3'd4;

  localparam logic [1:0] REG_READY_LIMIT = 2'd0;
  localparam logic [1:0] REG_RESP_LIMIT  = 2'd1;
  localparam logic [1:0] REG_TOKEN_LIMIT = 2'd2;
  localparam logic [1:0] REG_START_TOKEN = 2'd3;

  localparam logic [POLL_W-1:0]     READY_LIMIT_RST = 17'd256;
  localparam logic [RESP_LIM_W-1:0] RESP_LIMIT_RST  = 8'd10;
  localparam logic [POLL_W-1:0]     TOKEN_LIMIT_RST = 17'd65536;
  localparam logic [7:0]            START_TOKEN_RST = 8'hFE;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_READY = 4'd1,
    PH_FRAME = 4'd2,
    PH_RESP  = 4'd3,
    PH_TOKEN = 4'd4,
    PH_DATA  = 4'd5,
    PH_CRC1  = 4'd6,
    PH_CRC2  = 4'd7,
    PH_TRAIL = 4'd8
  } phase_t;

  typedef struct packed {
    logic              opcode;
    logic [5:0]        command_index;
    logic [31:0]       argument;
    logic [7:0]        crc_byte;
    logic [DLEN_W-1:0] data_length;
    logic [7:0]        rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       card_select;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] response;
  } out_item_t;

  typedef struct packed {
    logic [POLL_W-1:0]     ready_limit;
    logic [RESP_LIM_W-1:0] resp_limit;
    logic [POLL_W-1:0]     token_limit;
    logic [7:0]            start_token;
  } cfg_t;

endpackage

>>> rtl/sdspi_regs.sv
module sdspi_regs
  import sdspi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ready_limit <= READY_LIMIT_RST;
      cfg.resp_limit  <= RESP_LIMIT_RST;
      cfg.token_limit <= TOKEN_LIMIT_RST;
      cfg.start_token <= START_TOKEN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_READY_LIMIT: cfg.ready_limit <= pwdata[POLL_W-1:0];
        REG_RESP_LIMIT:  cfg.resp_limit  <= pwdata[RESP_LIM_W-1:0];
        REG_TOKEN_LIMIT: cfg.token_limit <= pwdata[POLL_W-1:0];
        REG_START_TOKEN: cfg.start_token <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_READY_LIMIT: prdata = APB_DATA_W'(cfg.ready_limit);
      REG_RESP_LIMIT:  prdata = APB_DATA_W'(cfg.resp_limit);
      REG_TOKEN_LIMIT: prdata = APB_DATA_W'(cfg.token_limit);
      REG_START_TOKEN: prdata = APB_DATA_W'(cfg.start_token);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/sd_spi_command_engine.sv
// SPI-mode SD card command engine. A start item loads the command frame and
// selects the card; every later item hands in the byte received in the
// exchange the last result asked for, and each item yields exactly one result
// (next byte to send, chip select level, a data byte, or end of transaction
// with status and the R1 response). One item is taken per clock unless in_stall
// holds it off; its result is registered. The result register is backed by
// a one-entry skid stage, so input stall depends only on that stage being
// full and never combinationally on output stall.
`include "sd_spi_command_engine_macros.svh"

module sd_spi_command_engine
  import sdspi_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int LEN_W = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int CMP_W = (LEN_W > DLEN_W) ? LEN_W : DLEN_W;

  cfg_t cfg;

  sdspi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  phase_t              phase, phase_next;
  logic [POLL_W-1:0]   poll_count, poll_next;
  logic [LEN_W-1:0]    byte_index, byte_index_next;
  logic [2:0]          frame_idx, frame_idx_next;
  logic [FRAME_W-1:0]  frame_store, frame_store_next;
  logic [LEN_W-1:0]    length_store, length_store_next;
  logic                select_flag, select_flag_next;
  logic [7:0]          response_store, response_store_next;

  out_item_t           res;
  out_item_t           skid_data;
  logic                skid_valid;
  logic                accept;

  logic [POLL_W-1:0]   poll_inc;
  logic [LEN_W-1:0]    byte_inc;
  logic [CMP_W-1:0]    len_ext;
  logic [LEN_W-1:0]    len_sat;
  logic                rx_ff, ready_to, resp_to, token_hit, token_to, frame_more;
  logic                len_zero;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;

  assign poll_inc   = poll_count + POLL_W'(1);
  assign byte_inc   = byte_index + LEN_W'(1);
  assign len_ext    = CMP_W'(in_data.data_length);
  assign len_sat    = (len_ext > CMP_W'(MAX_BLOCK_BYTES)) ? LEN_W'(MAX_BLOCK_BYTES)
                                                          : LEN_W'(len_ext);
  assign rx_ff      = (in_data.rx_byte == FILL_BYTE);
  assign ready_to   = (poll_inc >= cfg.ready_limit);
  assign resp_to    = (poll_inc > POLL_W'(cfg.resp_limit));
  assign token_hit  = (in_data.rx_byte == cfg.start_token);
  assign token_to   = (poll_inc >= cfg.token_limit);
  assign frame_more = (frame_idx < FRAME_BYTES);
  assign len_zero   = (length_store == '0);

  // next state
  always_comb begin
    phase_next          = phase;
    poll_next           = poll_count;
    byte_index_next     = byte_index;
    frame_idx_next      = frame_idx;
    frame_store_next    = frame_store;
    length_store_next   = length_store;
    select_flag_next    = select_flag;
    response_store_next = response_store;
    if (in_data.opcode == OP_START) begin
      frame_store_next    = {CMD_MARK | {2'b00, in_data.command_index},
                             in_data.argument, in_data.crc_byte};
      length_store_next   = len_sat;
      response_store_next = '0;
      poll_next           = '0;
      byte_index_next     = '0;
      frame_idx_next      = '0;
      select_flag_next    = 1'b1;
      phase_next          = PH_READY;
    end else begin
      unique case (phase)
        PH_READY: begin
          if (rx_ff) begin
            phase_next       = PH_FRAME;
            frame_idx_next   = 3'd1;
            frame_store_next = frame_store << 8;
          end else begin
            poll_next = poll_inc;
            if (ready_to) begin
              select_flag_next = 1'b0;
              phase_next       = PH_IDLE;
            end
          end
        end
        PH_FRAME: begin
          if (frame_more) begin
            frame_idx_next   = frame_idx + 3'd1;
            frame_store_next = frame_store << 8;
          end else begin
            phase_next = PH_RESP;
            poll_next  = '0;
          end
        end
        PH_RESP: begin
          poll_next = poll_inc;
          if (resp_to) begin
            select_flag_next = 1'b0;
            phase_next       = PH_IDLE;
          end else if (!rx_ff) begin
            response_store_next = in_data.rx_byte;
            if (len_zero) begin
              phase_next = PH_IDLE;
            end else if (in_data.rx_byte != 8'h00) begin
              select_flag_next = 1'b0;
              phase_next       = PH_IDLE;
            end else begin
              phase_next = PH_TOKEN;
              poll_next  = '0;
            end
          end
        end
        PH_TOKEN: begin
          if (token_hit) begin
            phase_next      = PH_DATA;
            byte_index_next = '0;
          end else begin
            poll_next = poll_inc;
            if (token_to) begin
              select_flag_next = 1'b0;
              phase_next       = PH_IDLE;
            end
          end
        end
        PH_DATA: begin
          byte_index_next = byte_inc;
          if (byte_inc >= length_store) phase_next = PH_CRC1;
        end
        PH_CRC1: phase_next = PH_CRC2;
        PH_CRC2: begin
          phase_next       = PH_TRAIL;
          select_flag_next = 1'b0;
        end
        PH_TRAIL: phase_next = PH_IDLE;
        default:  phase_next = PH_IDLE;
      endcase
    end
  end

  // result
  always_comb begin
    res             = '0;
    res.card_select = select_flag_next;
    res.response    = response_store_next;
    if (in_data.opcode == OP_START) begin
      res.tx_valid = 1'b1;
      res.tx_byte  = FILL_BYTE;
    end else begin
      unique case (phase)
        PH_READY: begin
          if (rx_ff) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = frame_store[FRAME_W-1 -: 8];
          end else if (ready_to) begin
            res.done_res = 1'b1;
            res.status   = ST_READY_TO;
          end else begin
            res.tx_valid = 1'b1;
            res.tx_byte  = FILL_BYTE;
          end
        end
        PH_FRAME: begin
          res.tx_valid = 1'b1;
          res.tx_byte  = frame_more ? frame_store[FRAME_W-1 -: 8] : FILL_BYTE;
        end
        PH_RESP: begin
          if (resp_to) begin
            res.done_res = 1'b1;
            res.status   = ST_RESP_TO;
          end else if (rx_ff) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = FILL_BYTE;
          end else if (len_zero) begin
            res.done_res = 1'b1;
            res.status   = ST_OK;
          end else if (in_data.rx_byte != 8'h00) begin
            res.done_res = 1'b1;
            res.status   = ST_NONZERO_R1;
          end else begin
            res.tx_valid = 1'b1;
            res.tx_byte  = FILL_BYTE;
          end
        end
        PH_TOKEN: begin
          if (!token_hit && token_to) begin
            res.done_res = 1'b1;
            res.status   = ST_TOKEN_TO;
          end else begin
            res.tx_valid = 1'b1;
            res.tx_byte  = FILL_BYTE;
          end
        end
        PH_DATA: begin
          res.tx_valid   = 1'b1;
          res.tx_byte    = FILL_BYTE;
          res.data_valid = 1'b1;
          res.data_byte  = in_data.rx_byte;
        end
        PH_CRC1, PH_CRC2: begin
          res.tx_valid = 1'b1;
          res.tx_byte  = FILL_BYTE;
        end
        PH_TRAIL: begin
          res.done_res = 1'b1;
          res.status   = ST_OK;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      poll_count     <= '0;
      byte_index     <= '0;
      frame_idx      <= '0;
      frame_store    <= '0;
      length_store   <= '0;
      select_flag    <= 1'b0;
      response_store <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      poll_count     <= poll_next;
      byte_index     <= byte_index_next;
      frame_idx      <= frame_idx_next;
      frame_store    <= frame_store_next;
      length_store   <= length_store_next;
      select_flag    <= select_flag_next;
      response_store <= response_store_next;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (accept) begin
      skid_data <= res;
    end
  end

  `SDSPI_ASSERT_IMP(a_skid_needs_out, skid_valid, out_valid, "skid full while result empty")
  `SDSPI_ASSERT_NEXT(a_skid_drains, skid_valid, out_valid, "skid transfer lost")
  `SDSPI_ASSERT_IMP(a_frame_selected, phase == PH_FRAME, select_flag, "frame sent deselected")
  `SDSPI_ASSERT_IMP(a_trail_deselected, phase == PH_TRAIL, !select_flag, "trail byte selected")

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import sdspi_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PER_SETTING = 213;
  localparam int N_SETTINGS  = 6;

  class sd_host_tracker;
    logic [POLL_W-1:0]     ready_lim;
    logic [RESP_LIM_W-1:0] resp_lim;
    logic [POLL_W-1:0]     token_lim;
    logic [7:0]            token_byte;

    phase_t                cur_phase;
    logic [POLL_W-1:0]     poll_cnt;
    logic [DLEN_W-1:0]     byte_idx;
    logic [FRAME_W-1:0]    frame;
    logic [DLEN_W-1:0]     blk_len;
    logic                  selected;
    logic [7:0]            r1_byte;

    out_item_t expected_exchanges[$];
    int errors;
    int n_items;
    int n_checked;
    int n_data;
    int ends_by_status[8];

    function new();
      ready_lim  = READY_LIMIT_RST;
      resp_lim   = RESP_LIMIT_RST;
      token_lim  = TOKEN_LIMIT_RST;
      token_byte = START_TOKEN_RST;
      cur_phase  = PH_IDLE;
      poll_cnt   = '0;
      byte_idx   = '0;
      frame      = '0;
      blk_len    = '0;
      selected   = 1'b0;
      r1_byte    = '0;
      errors     = 0;
      n_items    = 0;
      n_checked  = 0;
      n_data     = 0;
      foreach (ends_by_status[i]) ends_by_status[i] = 0;
    endfunction

    function int pending();
      return expected_exchanges.size();
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_READY_LIMIT: return 32'(ready_lim);
        REG_RESP_LIMIT:  return 32'(resp_lim);
        REG_TOKEN_LIMIT: return 32'(token_lim);
        default:         return 32'(token_byte);
      endcase
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_READY_LIMIT: ready_lim  = val[POLL_W-1:0];
        REG_RESP_LIMIT:  resp_lim   = val[RESP_LIM_W-1:0];
        REG_TOKEN_LIMIT: token_lim  = val[POLL_W-1:0];
        default:         token_byte = val[7:0];
      endcase
    endfunction

    function logic [7:0] frame_byte(int k);
      return frame[FRAME_W-1-8*k -: 8];
    endfunction

    function out_item_t ask(logic [7:0] b);
      out_item_t r;
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte  = b;
      return r;
    endfunction

    function out_item_t finish(logic [2:0] st);
      out_item_t r;
      r = '0;
      selected   = 1'b0;
      cur_phase  = PH_IDLE;
      r.done_res = 1'b1;
      r.status   = st;
      return r;
    endfunction

    // next exchange request for one accepted input transfer
    function void predict_exchange(in_item_t it);
      out_item_t r;
      r = '0;
      n_items++;
      if (it.opcode == OP_START) begin
        frame = {CMD_MARK | {2'b00, it.command_index}, it.argument, it.crc_byte};
        blk_len = (it.data_length > MAX_BLOCK_BYTES_DEF) ?
                  DLEN_W'(MAX_BLOCK_BYTES_DEF) : it.data_length;
        r1_byte   = '0;
        poll_cnt  = '0;
        byte_idx  = '0;
        selected  = 1'b1;
        cur_phase = PH_READY;
        r = ask(FILL_BYTE);
      end else begin
        case (cur_phase)
          PH_READY: begin
            if (it.rx_byte == FILL_BYTE) begin
              cur_phase = PH_FRAME;
              byte_idx  = DLEN_W'(1);
              r = ask(frame_byte(0));
            end else begin
              poll_cnt = poll_cnt + 1'b1;
              if (poll_cnt >= ready_lim) r = finish(ST_READY_TO);
              else r = ask(FILL_BYTE);
            end
          end
          PH_FRAME: begin
            if (byte_idx < FRAME_BYTES) begin
              r = ask(frame_byte(int'(byte_idx)));
              byte_idx = byte_idx + 1'b1;
            end else begin
              cur_phase = PH_RESP;
              poll_cnt  = '0;
              r = ask(FILL_BYTE);
            end
          end
          PH_RESP: begin
            poll_cnt = poll_cnt + 1'b1;
            if (poll_cnt > resp_lim) begin
              r = finish(ST_RESP_TO);
            end else if (it.rx_byte == FILL_BYTE) begin
              r = ask(FILL_BYTE);
            end else begin
              r1_byte = it.rx_byte;
              if (blk_len == 0) begin
                cur_phase  = PH_IDLE;
                r.done_res = 1'b1;
                r.status   = ST_OK;
              end else if (it.rx_byte != 8'h00) begin
                r = finish(ST_NONZERO_R1);
              end else begin
                cur_phase = PH_TOKEN;
                poll_cnt  = '0;
                r = ask(FILL_BYTE);
              end
            end
          end
          PH_TOKEN: begin
            if (it.rx_byte == token_byte) begin
              cur_phase = PH_DATA;
              byte_idx  = '0;
              r = ask(FILL_BYTE);
            end else begin
              poll_cnt = poll_cnt + 1'b1;
              if (poll_cnt >= token_lim) r = finish(ST_TOKEN_TO);
              else r = ask(FILL_BYTE);
            end
          end
          PH_DATA: begin
            byte_idx = byte_idx + 1'b1;
            if (byte_idx >= blk_len) cur_phase = PH_CRC1;
            r = ask(FILL_BYTE);
            r.data_valid = 1'b1;
            r.data_byte  = it.rx_byte;
          end
          PH_CRC1: begin
            cur_phase = PH_CRC2;
            r = ask(FILL_BYTE);
          end
          PH_CRC2: begin
            cur_phase = PH_TRAIL;
            selected  = 1'b0;
            r = ask(FILL_BYTE);
          end
          PH_TRAIL: begin
            cur_phase  = PH_IDLE;
            r.done_res = 1'b1;
            r.status   = ST_OK;
          end
          default: cur_phase = PH_IDLE;
        endcase
      end
      r.card_select = selected;
      r.response    = r1_byte;
      expected_exchanges.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t MISMATCH %s", $time, msg);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task match_result(out_item_t got);
      out_item_t want;
      n_checked++;
      if (expected_exchanges.size() == 0) begin
        report("result transfer with nothing expected");
        return;
      end
      want = expected_exchanges.pop_front();
      if (want.done_res) ends_by_status[want.status]++;
      if (want.data_valid) n_data++;
      check_field("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
      check_field("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
      check_field("card_select", 32'(got.card_select), 32'(want.card_select));
      check_field("data_valid", 32'(got.data_valid), 32'(want.data_valid));
      check_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
      check_field("done_res", 32'(got.done_res), 32'(want.done_res));
      check_field("status", 32'(got.status), 32'(want.status));
      check_field("response", 32'(got.response), 32'(want.response));
    endtask

    task check_reg(logic [1:0] idx, logic [31:0] rd);
      check_field($sformatf("readback of register %0d", idx), rd, reg_value(idx));
    endtask
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sd_host_tracker sb;
  bit quiet = 1'b0;
  int cycles = 0;

  // card behavior for the running transaction
  int busy_left;
  int resp_left;
  int tok_left;
  logic [7:0] r1_plan;

  int unsigned set_ready[N_SETTINGS] = '{0, 1, 3, 65536, 16, 256};
  int unsigned set_resp [N_SETTINGS] = '{0, 1, 10, 255, 4, 10};
  int unsigned set_token[N_SETTINGS] = '{0, 1, 5, 65536, 40, 65536};
  int unsigned set_start[N_SETTINGS] = '{8'h00, 8'hFE, 8'hFE, 8'hFF, 8'hA5, 8'hFE};

  sd_spi_command_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.match_result(out_data);
  end

  // result side: random hold-off per transfer, one long hold to back up the engine
  initial begin
    int w;
    bit held;
    held = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      w = quiet ? 0 : $urandom_range(0, 8);
      if (!held && sb.n_checked >= 300) begin
        w = 120;
        held = 1'b1;
      end
      if (w > 0) begin
        out_stall = 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic in_item_t rand_fill();
    in_item_t it;
    it.opcode        = OP_RX;
    it.command_index = 6'($urandom);
    it.argument      = $urandom;
    it.crc_byte      = 8'($urandom);
    it.data_length   = 10'($urandom);
    it.rx_byte       = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t plan_start();
    in_item_t it;
    int r;
    it = rand_fill();
    it.opcode = OP_START;
    r = $urandom_range(0, 199);
    if (r < 50) it.data_length = '0;
    else if (r < 160) it.data_length = 10'($urandom_range(1, 16));
    else if (r < 197) it.data_length = 10'($urandom_range(17, 80));
    else it.data_length = 10'($urandom_range(500, 1023));
    busy_left = $urandom_range(0, 3);
    if (sb.ready_lim <= 40 && $urandom_range(0, 9) == 0) busy_left = int'(sb.ready_lim) + 1;
    resp_left = $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) resp_left = int'(sb.resp_lim) + $urandom_range(0, 1);
    tok_left = $urandom_range(0, 3);
    if (sb.token_lim <= 64 && $urandom_range(0, 9) == 0) tok_left = int'(sb.token_lim);
    r1_plan = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 254)) : 8'h00;
    return it;
  endfunction

  function automatic in_item_t next_item();
    in_item_t it;
    logic [8:0] v;
    it = rand_fill();
    case (sb.cur_phase)
      PH_IDLE: begin
        if ($urandom_range(0, 9) != 0) it = plan_start();
      end
      PH_READY: begin
        if (busy_left > 0) begin
          it.rx_byte = 8'($urandom_range(0, 254));
          busy_left--;
        end else begin
          it.rx_byte = FILL_BYTE;
        end
      end
      PH_RESP: begin
        if (resp_left > 0) begin
          it.rx_byte = FILL_BYTE;
          resp_left--;
        end else begin
          it.rx_byte = r1_plan;
        end
      end
      PH_TOKEN: begin
        if (tok_left > 0) begin
          v = 9'($urandom_range(0, 254));
          if (v >= sb.token_byte) v = v + 1'b1;
          it.rx_byte = v[7:0];
          tok_left--;
        end else begin
          it.rx_byte = sb.token_byte;
        end
      end
      default: ;
    endcase
    if (sb.cur_phase != PH_IDLE) begin
      if ($urandom_range(0, 49) == 0) it = plan_start();
      else if ($urandom_range(0, 49) == 0) it.rx_byte = 8'($urandom);
    end
    return it;
  endfunction

  function automatic in_item_t mk_start(logic [5:0] idx, logic [31:0] arg, logic [7:0] crc,
                                        logic [9:0] len);
    in_item_t it;
    it = '0;
    it.opcode        = OP_START;
    it.command_index = idx;
    it.argument      = arg;
    it.crc_byte      = crc;
    it.data_length   = len;
    return it;
  endfunction

  function automatic in_item_t mk_rx(logic [7:0] b);
    in_item_t it;
    it = '0;
    it.opcode  = OP_RX;
    it.rx_byte = b;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.predict_exchange(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] val,
                            output logic [31:0] rd);
    paddr   = {idx, 2'b00};
    pwdata  = val;
    pwrite  = wr;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (wr) sb.set_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    apb_access(1'b1, idx, val, rd);
    apb_access(1'b0, idx, '0, rd);
    sb.check_reg(idx, rd);
  endtask

  initial begin
    in_item_t it;
    in_item_t directed[$];
    bit skip;
    int fed;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // byte while idle, command-only with nonzero R1, oversize length abandoned by
    // a new start, then nonzero R1 with a data phase
    directed.push_back(mk_rx(8'h5A));
    directed.push_back(mk_start(6'd0, 32'h0000_0000, 8'h00, 10'd0));
    directed.push_back(mk_rx(8'h00));
    directed.push_back(mk_rx(FILL_BYTE));
    repeat (6) directed.push_back(mk_rx(8'h00));
    directed.push_back(mk_rx(FILL_BYTE));
    directed.push_back(mk_rx(8'h05));
    directed.push_back(mk_start(6'd63, 32'hFFFF_FFFF, 8'hFF, 10'd1023));
    directed.push_back(mk_rx(FILL_BYTE));
    directed.push_back(mk_start(6'd17, 32'h1234_5678, 8'h95, 10'd2));
    directed.push_back(mk_rx(FILL_BYTE));
    repeat (6) directed.push_back(mk_rx(8'hFF));
    directed.push_back(mk_rx(8'h01));
    foreach (directed[i]) send_item(directed[i]);

    for (int p = 0; p < N_SETTINGS; p++) begin
      drain();
      write_reg(REG_READY_LIMIT, set_ready[p]);
      write_reg(REG_RESP_LIMIT, set_resp[p]);
      write_reg(REG_TOKEN_LIMIT, set_token[p]);
      write_reg(REG_START_TOKEN, set_start[p]);
      quiet = (p == 2 || p == 4);
      fed = 0;
      while (fed < PER_SETTING || sb.cur_phase != PH_IDLE) begin
        skip = (sb.cur_phase == PH_IDLE);
        it = next_item();
        skip = skip && (it.opcode == OP_RX);
        send_item(it);
        if (!skip) fed++;
      end
    end
    quiet = 1'b1;
    drain();
    repeat (8) @(negedge clk);

    $display("run covered %0d input transfers, %0d results checked, %0d block data bytes",
             sb.n_items, sb.n_checked, sb.n_data);
    $display("ends: ok %0d, ready timeout %0d, response timeout %0d, R1 error %0d, %s %0d",
             sb.ends_by_status[ST_OK], sb.ends_by_status[ST_READY_TO],
             sb.ends_by_status[ST_RESP_TO], sb.ends_by_status[ST_NONZERO_R1],
             "token timeout", sb.ends_by_status[ST_TOKEN_TO]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sd_spi_command_engine.f
+incdir+rtl
rtl/sdspi_pkg.sv
rtl/sdspi_regs.sv
rtl/sd_spi_command_engine.sv
sim/tb.sv
